FILE: hw/rtl/hj_pkg.sv
`default_nettype none
package hj_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int ADDR_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int WORD_W = 64;
	localparam int FUNC_W = 2;
	localparam int CFG_W = 2;

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PROBE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_W-1:0] CFG_KEY_WORDS = 2'd0;
	localparam logic [CFG_W-1:0] CFG_LEFT_WORDS = 2'd1;
	localparam logic [CFG_W-1:0] CFG_RIGHT_WORDS = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] key_lo;
		logic [WORD_W-1:0] key_hi;
		logic [WORD_W-1:0] left_lo;
		logic [WORD_W-1:0] left_hi;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic              key_hi_used;
		logic [WORD_W-1:0] key0;
		logic [WORD_W-1:0] key1;
		logic [WORD_W-1:0] right0;
		logic [WORD_W-1:0] right1;
	} probe_cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] key0;
		logic [WORD_W-1:0] key1;
		logic [WORD_W-1:0] left0;
		logic [WORD_W-1:0] left1;
		logic [WORD_W-1:0] right0;
		logic [WORD_W-1:0] right1;
		logic              last;
		logic              overflow;
	} result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hash_join_build_probe.sv
`default_nettype none
// Equi-join engine with a 64-entry build table and exact key match.
//
// Input channel (in_valid / in_stall): func selects build, probe or clear.
// A build appends key and left words to the table; a build into a full
// table is dropped and sets the sticky overflow flag. A clear empties the
// table. A probe scans all stored entries in insertion order and emits
// one item per entry with an equal key; the final item carries last. A
// probe that matches nothing emits nothing. in_stall is high while a
// probe scan runs.
//
// During a probe the table memory is read one entry per cycle, except
// while the scan holds; the read data is registered, and the last match
// is held back in a candidate register so that it can be marked. The first
// result is pushed when the second match is read, or after the last read
// when the probe has a single match.
// Output channel (out_valid / out_stall) has a result register; a stalled
// result holds, and the scan pauses when it needs to emit another match.
// The input side takes the next item while the final result still waits.
// Reset empties the table, clears overflow and sets all word counts to 1.
// Configuration is written through cfg_write / cfg_index / cfg_data.
module hash_join_build_probe (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write,
	input  wire logic [hj_pkg::CFG_W-1:0]    cfg_index,
	input  wire logic [hj_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [hj_pkg::FUNC_W-1:0]   func,
	input  wire logic [hj_pkg::WORD_W-1:0]   key_word_0,
	input  wire logic [hj_pkg::WORD_W-1:0]   key_word_1,
	input  wire logic [hj_pkg::WORD_W-1:0]   value_word_0,
	input  wire logic [hj_pkg::WORD_W-1:0]   value_word_1,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [hj_pkg::WORD_W-1:0]        out_key_0,
	output logic [hj_pkg::WORD_W-1:0]        out_key_1,
	output logic [hj_pkg::WORD_W-1:0]        left_word_0,
	output logic [hj_pkg::WORD_W-1:0]        left_word_1,
	output logic [hj_pkg::WORD_W-1:0]        right_word_0,
	output logic [hj_pkg::WORD_W-1:0]        right_word_1,
	output logic                             last,
	output logic                             overflow
);
	import hj_pkg::*;

	logic [CFG_W-1:0] key_words_q, left_words_q, right_words_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;

	logic       accept, table_full, do_build, busy;
	probe_cmd_t cmd;
	entry_t     wr_entry, rd_entry;
	logic       rd_en;
	logic [ADDR_W-1:0] rd_addr;
	result_t    result;

	assign in_stall = busy;
	assign accept = in_valid && !busy;
	assign table_full = (count_q == CNT_W'(TABLE_ENTRIES));
	assign do_build = accept && (func == FUNC_BUILD) && !table_full;

	always_comb begin
		wr_entry.key_lo = key_word_0;
		wr_entry.key_hi = key_word_1;
		wr_entry.left_lo = (left_words_q != '0) ? value_word_0 : '0;
		wr_entry.left_hi = left_words_q[1] ? value_word_1 : '0;

		// key count 0 counts as 1; right words zeroed when unused
		cmd.start = accept && (func == FUNC_PROBE);
		cmd.key_hi_used = key_words_q[1];
		cmd.key0 = key_word_0;
		cmd.key1 = key_words_q[1] ? key_word_1 : '0;
		cmd.right0 = (right_words_q != '0) ? value_word_0 : '0;
		cmd.right1 = right_words_q[1] ? value_word_1 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_words_q <= CFG_W'(1);
			left_words_q <= CFG_W'(1);
			right_words_q <= CFG_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_KEY_WORDS:   key_words_q <= cfg_data;
				CFG_LEFT_WORDS:  left_words_q <= cfg_data;
				CFG_RIGHT_WORDS: right_words_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			unique case (func)
				FUNC_BUILD: begin
					if (table_full) begin
						overflow_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				FUNC_CLEAR: count_q <= '0;
				default: ;
			endcase
		end
	end

	hj_table_ram u_ram (
		.clk   (clk),
		.we    (do_build),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	hj_probe_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.left_words    (left_words_q),
		.entry_count   (count_q),
		.overflow_flag (overflow_q),
		.rd_data       (rd_entry),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result        (result)
	);

	assign out_key_0 = result.key0;
	assign out_key_1 = result.key1;
	assign left_word_0 = result.left0;
	assign left_word_1 = result.left1;
	assign right_word_0 = result.right0;
	assign right_word_1 = result.right1;
	assign last = result.last;
	assign overflow = result.overflow;

endmodule
`default_nettype wire

FILE: hw/rtl/hj_table_ram.sv
`default_nettype none
module hj_table_ram (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [hj_pkg::ADDR_W-1:0] waddr,
	input  wire hj_pkg::entry_t        wdata,
	input  wire logic                  re,
	input  wire logic [hj_pkg::ADDR_W-1:0] raddr,
	output hj_pkg::entry_t             rdata
);
	import hj_pkg::*;

	entry_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/hj_probe_scan.sv
`default_nettype none
module hj_probe_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire hj_pkg::probe_cmd_t        cmd,
	input  wire logic [hj_pkg::CFG_W-1:0]  left_words,
	input  wire logic [hj_pkg::CNT_W-1:0]  entry_count,
	input  wire logic                      overflow_flag,
	input  wire hj_pkg::entry_t            rd_data,
	output logic                           rd_en,
	output logic [hj_pkg::ADDR_W-1:0]      rd_addr,
	output logic                           busy,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output hj_pkg::result_t                result
);
	import hj_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  addr_q;
	logic              s1_valid_q;
	logic              key_hi_used_q;
	logic [WORD_W-1:0] key0_q, key1_q, right0_q, right1_q;
	logic              cand_valid_q;
	logic [WORD_W-1:0] cand_left0_q, cand_left1_q;
	logic              out_valid_q;
	result_t           result_q;

	logic out_free, match_s1, hold, issue, push, push_last;

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		match_s1 = s1_valid_q && (rd_data.key_lo == key0_q) &&
			(!key_hi_used_q || (rd_data.key_hi == key1_q));
		// a second match while the output is full stalls the scan
		hold = match_s1 && cand_valid_q && !out_free;
		issue = (state_q == ST_SCAN) && !hold && (addr_q < entry_count);
		push_last = (state_q == ST_FLUSH);
		push = cand_valid_q && out_free &&
			(((state_q == ST_SCAN) && match_s1) || push_last);
	end

	assign rd_en = issue;
	assign rd_addr = addr_q[ADDR_W-1:0];
	assign busy = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			s1_valid_q <= 1'b0;
			cand_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						addr_q <= '0;
						s1_valid_q <= 1'b0;
						cand_valid_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!hold) begin
						s1_valid_q <= issue;
						if (issue) begin
							addr_q <= addr_q + CNT_W'(1);
						end else begin
							state_q <= ST_FLUSH;
						end
						if (match_s1) begin
							cand_valid_q <= 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!cand_valid_q || out_free) begin
						cand_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && cmd.start) begin
			key_hi_used_q <= cmd.key_hi_used;
			key0_q <= cmd.key0;
			key1_q <= cmd.key1;
			right0_q <= cmd.right0;
			right1_q <= cmd.right1;
		end
		if ((state_q == ST_SCAN) && !hold && match_s1) begin
			cand_left0_q <= rd_data.left_lo;
			cand_left1_q <= rd_data.left_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			result_q.key0 <= key0_q;
			result_q.key1 <= key1_q;
			result_q.left0 <= (left_words != '0) ? cand_left0_q : '0;
			result_q.left1 <= left_words[1] ? cand_left1_q : '0;
			result_q.right0 <= right0_q;
			result_q.right1 <= right1_q;
			result_q.last <= push_last;
			result_q.overflow <= overflow_flag;
		end
	end

endmodule
`default_nettype wire
